>>> hdl/zbp_pkg.sv
// Shared constants, types and byte-order helpers of the zero block packer.
package zbp_pkg;

   localparam int BLOCK_BYTES     = 512;
   localparam int LINE_BLOCKS     = 96;
   localparam int ITEM_BYTES      = 16;
   localparam int ITEMS_PER_BLOCK = BLOCK_BYTES / ITEM_BYTES;
   localparam int IDX_W           = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;
   localparam int BP_W            = $clog2(LINE_BLOCKS);
   localparam int LINE_WORDS      = LINE_BLOCKS / 32;
   localparam int NB_W            = 5;

   // Bytes 00 58 44 49 in transmission order, and bytes 49 44 58 00.
   localparam logic [31:0] MARK_WORD = 32'h4944_5800;
   localparam logic [31:0] META_TAG  = 32'h0058_4449;
   localparam logic [NB_W-1:0] FULL_BYTES = NB_W'(ITEM_BYTES);

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_LINE = 2'd1,
      KIND_META = 2'd2
   } kind_type;

   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic load_data;
      logic load_line;
      logic load_meta;
   } cmd_type;

   typedef struct packed {
      logic block_end;
      logic acc_nonzero;
      logic acc_eof;
      logic acc_line_due;
      logic out_free;
      logic last_read;
      logic file_end;
      logic line_pending;
   } status_type;

   // Places a word so that its most significant byte lands in the lowest byte lane.
   function automatic logic [31:0] be32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [63:0] be64(input logic [63:0] v);
      return {be32(v[31:0]), be32(v[63:32])};
   endfunction

endpackage

>>> hdl/zbp_if.sv
// Request and response channel interfaces of the zero block packer.
interface zbp_req_if import zbp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [63:0]     data_low;
   logic [63:0]     data_high;
   logic [NB_W-1:0] bytes_valid;
   logic            end_of_file;

   modport source (output valid, data_low, data_high, bytes_valid, end_of_file,
                   input ready);
   modport sink   (input valid, data_low, data_high, bytes_valid, end_of_file,
                   output ready);
endinterface

interface zbp_rsp_if import zbp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      kind;
   logic [63:0]     out_low;
   logic [63:0]     out_high;
   logic [NB_W-1:0] out_bytes;
   logic            last_of_run;

   modport source (output valid, kind, out_low, out_high, out_bytes, last_of_run,
                   input ready);
   modport sink   (input valid, kind, out_low, out_high, out_bytes, last_of_run,
                   output ready);
endinterface

>>> hdl/zbp_datapath.sv
// Datapath: block buffer, bitmap counters and the response output register.
module zbp_datapath import zbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  logic [63:0]     data_low,
   input  logic [63:0]     data_high,
   input  logic [NB_W-1:0] bytes_valid,
   input  logic            end_of_file,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      kind,
   output logic [63:0]     out_low,
   output logic [63:0]     out_high,
   output logic [NB_W-1:0] out_bytes,
   output logic            last_of_run
);

   logic [127:0]    block_store [ITEMS_PER_BLOCK];
   logic [127:0]    store_q_ff;

   logic            nonzero_ff;
   logic [IDX_W-1:0] item_in_block_ff;
   logic [BP_W-1:0] bit_position_ff;
   logic [31:0]     presence_ff [LINE_WORDS];
   logic [31:0]     running_count_ff;
   logic [31:0]     line_start_ff;
   logic [63:0]     total_bytes_ff;
   logic [31:0]     lines_emitted_ff;
   logic            eof_ff;
   logic            line_due_ff;
   logic [IDX_W-1:0] last_idx_ff;
   logic [NB_W-1:0] final_nb_ff;
   logic [IDX_W-1:0] rd_ptr_ff;
   logic            rsp_valid_ff;

   logic [1:0]      kind_ff;
   logic [127:0]    out_word_ff;
   logic [NB_W-1:0] out_bytes_ff;
   logic            last_ff;

   logic [NB_W-1:0] nb_eff;
   logic [127:0]    byte_mask;
   logic [127:0]    item_word;
   logic            item_nz;
   logic            marked;
   logic [127:0]    line_word;
   logic [127:0]    meta_word;

   // Bytes beyond the valid count of a final transaction are forced to zero.
   always_comb begin
      nb_eff = bytes_valid;
      if (!end_of_file || bytes_valid == '0 || bytes_valid > FULL_BYTES) begin
         nb_eff = FULL_BYTES;
      end
      for (int b = 0; b < ITEM_BYTES; b++) begin
         byte_mask[b*8 +: 8] = (NB_W'(b) < nb_eff) ? 8'hff : 8'h00;
      end
   end

   assign item_word = {data_high, data_low} & byte_mask;
   assign item_nz   = |item_word;

   assign marked    = !eof_ff && (running_count_ff == '0);
   assign line_word = {be32(presence_ff[2]), be32(presence_ff[1]), be32(presence_ff[0]),
                       marked ? MARK_WORD : be32(line_start_ff)};
   assign meta_word = {be64(total_bytes_ff), be32(lines_emitted_ff + 32'd2), META_TAG};

   assign status.block_end    = end_of_file ||
                                (item_in_block_ff == IDX_W'(ITEMS_PER_BLOCK - 1));
   assign status.acc_nonzero  = nonzero_ff | item_nz;
   assign status.acc_eof      = end_of_file;
   assign status.acc_line_due = bit_position_ff == BP_W'(LINE_BLOCKS - 1);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.last_read    = rd_ptr_ff == last_idx_ff;
   assign status.file_end     = eof_ff;
   assign status.line_pending = line_due_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         block_store[item_in_block_ff] <= item_word;
      end
      if (cmd.rd_issue) begin
         store_q_ff <= block_store[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_meta) begin
         nonzero_ff       <= 1'b0;
         item_in_block_ff <= '0;
         bit_position_ff  <= '0;
         for (int w = 0; w < LINE_WORDS; w++) begin
            presence_ff[w] <= '0;
         end
         running_count_ff <= '0;
         line_start_ff    <= '0;
         total_bytes_ff   <= '0;
         lines_emitted_ff <= '0;
         eof_ff           <= 1'b0;
         line_due_ff      <= 1'b0;
         last_idx_ff      <= '0;
         final_nb_ff      <= FULL_BYTES;
         rd_ptr_ff        <= '0;
      end else begin
         if (cmd.accept) begin
            total_bytes_ff <= total_bytes_ff + 64'(nb_eff);
            if (status.block_end) begin
               nonzero_ff       <= 1'b0;
               item_in_block_ff <= '0;
               eof_ff           <= end_of_file;
               line_due_ff      <= !end_of_file && status.acc_line_due;
               last_idx_ff      <= item_in_block_ff;
               final_nb_ff      <= nb_eff;
               rd_ptr_ff        <= '0;
               if (status.acc_nonzero) begin
                  presence_ff[bit_position_ff[BP_W-1:5]][bit_position_ff[4:0]] <= 1'b1;
                  running_count_ff <= running_count_ff + 32'd1;
               end
               if (!end_of_file) begin
                  bit_position_ff <= status.acc_line_due ? '0 : bit_position_ff + 1'b1;
               end
            end else begin
               nonzero_ff       <= status.acc_nonzero;
               item_in_block_ff <= item_in_block_ff + 1'b1;
            end
         end
         if (cmd.load_data) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (cmd.load_line && !eof_ff) begin
            line_start_ff    <= running_count_ff;
            lines_emitted_ff <= lines_emitted_ff + 32'd1;
            line_due_ff      <= 1'b0;
            for (int w = 0; w < LINE_WORDS; w++) begin
               presence_ff[w] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_data || cmd.load_line || cmd.load_meta) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         kind_ff      <= KIND_DATA;
         out_word_ff  <= store_q_ff;
         out_bytes_ff <= (eof_ff && status.last_read) ? final_nb_ff : FULL_BYTES;
         last_ff      <= status.last_read && !eof_ff && !line_due_ff;
      end else if (cmd.load_line) begin
         kind_ff      <= KIND_LINE;
         out_word_ff  <= line_word;
         out_bytes_ff <= FULL_BYTES;
         last_ff      <= !eof_ff;
      end else if (cmd.load_meta) begin
         kind_ff      <= KIND_META;
         out_word_ff  <= meta_word;
         out_bytes_ff <= FULL_BYTES;
         last_ff      <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign kind        = kind_ff;
   assign out_low     = out_word_ff[63:0];
   assign out_high    = out_word_ff[127:64];
   assign out_bytes   = out_bytes_ff;
   assign last_of_run = last_ff;

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_data, cmd.load_line, cmd.load_meta}))
      else $error("More than one response loaded in a cycle.");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_data || cmd.load_line || cmd.load_meta) |-> status.out_free)
      else $error("Response register overwritten while still held.");

   a_meta_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_meta |=> (running_count_ff == '0 && bit_position_ff == '0 &&
                         total_bytes_ff == '0))
      else $error("File state not cleared after the metadata line.");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_position_ff < BP_W'(LINE_BLOCKS))
      else $error("Bitmap position beyond the line.");

endmodule

>>> hdl/zbp_controller.sv
// Controller: sequences acceptance, block replay, bitmap and metadata lines.
module zbp_controller import zbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SEND,
      S_LINE,
      S_META
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = ready_ff && req_valid;
            if (cmd.accept && status.block_end) begin
               if (status.acc_nonzero) begin
                  state_in = S_READ;
               end else if (status.acc_eof || status.acc_line_due) begin
                  state_in = S_LINE;
               end
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (status.out_free) begin
               cmd.load_data = 1'b1;
               if (!status.last_read) begin
                  state_in = S_READ;
               end else if (status.file_end || status.line_pending) begin
                  state_in = S_LINE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LINE: begin
            if (status.out_free) begin
               cmd.load_line = 1'b1;
               state_in      = status.file_end ? S_META : S_IDLE;
            end
         end
         S_META: begin
            if (status.out_free) begin
               cmd.load_meta = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

>>> hdl/zero_block_packer.sv
// Top level of the zero block packer: controller and datapath.
// The request channel carries the file as 16-byte transactions; end_of_file
// marks the final one, whose bytes_valid may be below 16. The response channel
// returns block data (kind 0), bitmap lines (kind 1) and the closing metadata
// line (kind 2); last_of_run flags the final response caused by a request.
// A transaction that does not end a block leaves the controller idle, and such
// transactions may follow each other in consecutive cycles.
// A transaction that ends a block holding any nonzero byte replays the whole
// block from the internal buffer, each response by a buffer read and then an
// output register load. A bitmap line or metadata line adds one response each.
// An all-zero block produces no data responses. The first data response passes
// the buffer read register and then the output register after the block-ending
// transaction is accepted; after an all-zero block, a due bitmap line is loaded
// from the S_LINE state once the response register is free.
// When the receiver stalls, the response register holds its transaction and
// the replay waits; no request is taken until the replay has finished.
// Reset is synchronous and clears all counters; the block buffer needs no
// clearing, since each entry is written before it is replayed.
// Request ready rises the cycle after reset is released.
module zero_block_packer import zbp_pkg::*; (
   input logic    clock,
   input logic    reset,
   zbp_req_if.sink   req_bus,
   zbp_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   zbp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   zbp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_low    (req_bus.data_low),
      .data_high   (req_bus.data_high),
      .bytes_valid (req_bus.bytes_valid),
      .end_of_file (req_bus.end_of_file),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .kind        (rsp_bus.kind),
      .out_low     (rsp_bus.out_low),
      .out_high    (rsp_bus.out_high),
      .out_bytes   (rsp_bus.out_bytes),
      .last_of_run (rsp_bus.last_of_run)
   );

endmodule
